### hdl/linear_probe_hash_index_unit_assert.svh
// assertion macros for the hash index unit
`ifndef LINEAR_PROBE_HASH_INDEX_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_INDEX_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LPHI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash index check failed");

// next-cycle implication, sampled on clk, off while in reset
`define LPHI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash index check failed");

`endif

### hdl/lphi_pkg.sv
// shared types, codes and constants of the hash index unit
`default_nettype none

package lphi_pkg;

    localparam int SLOTS_DEF       = 1024;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 11;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 48;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

    // slot tag codes
    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    // finalizer multipliers
    localparam logic [63:0] HASH_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_C2 = 64'h94d049bb133111eb;

    // what the back end has to do with an item
    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_FIND   = 3'd1,
        K_REMOVE = 3'd2,
        K_ZERO   = 3'd3,
        K_NOP    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
    } item_t;

endpackage

`default_nettype wire

### hdl/linear_probe_hash_index_unit.sv
// top level of the linear probing hash index unit
`default_nettype none

// Open-addressing hash table of SLOTS entries mapping nonzero 64-bit keys to
// handles, with insert, find and remove. The front end takes one beat, then
// runs the 64-bit finalizer hash of an insert, find or remove key on one
// shared 32x32 multiplier, and hands the item to a two-entry queue. The back
// end passes each item through its idle, start and result states, plus a read
// and a check state for each slot probed (one registered memory read, one
// check); with short probe runs the front end sets the pace, while a long run
// can walk up to SLOTS slots. After reset, and after a remove that leaves the
// table empty, the back end sweeps the tag memory and starts no new item
// meanwhile.
module linear_probe_hash_index_unit
    import lphi_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // cmd [1:0], key [65:2], value [97:66], zero fill above
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status [1:0], found_value [33:2], live_entries [44:34], zero fill above
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int Q_W   = IDX_W + $bits(item_t);
    localparam int LIMIT = SLOTS - SLOTS / 4;

    logic                push_valid, push_ready;
    item_t               push_item;
    logic [IDX_W-1:0]    push_home;
    logic                q_valid, q_ready;
    logic [Q_W-1:0]      q_data;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  found_value;
    logic [LIVE_W-1:0]   live_entries;

    // hash front end
    lphi_hash_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tdata[1:0]),
        .in_key     (s_axis_tdata[65:2]),
        .in_value   (s_axis_tdata[97:66]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .push_home  (push_home)
    );

    // decoupling queue
    lphi_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_home, push_item}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // probe back end
    lphi_probe_back #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (item_t'(q_data[$bits(item_t)-1:0])),
        .q_home           (q_data[Q_W-1:$bits(item_t)]),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_status       (status),
        .out_found_value  (found_value),
        .out_live_entries (live_entries)
    );

    assign m_axis_tdata = {
        (OUT_DATA_W - STATUS_W - VALUE_W - LIVE_W)'(0), live_entries, found_value, status
    };

`include "linear_probe_hash_index_unit_assert.svh"

    // a handle only comes back with a successful lookup
    `LPHI_ASSERT_IMP(a_fv_only_ok, m_axis_tvalid && (status != ST_OK), found_value == '0)
    // the live count never passes the load limit
    `LPHI_ASSERT_IMP(a_live_limit, m_axis_tvalid, 32'(live_entries) <= 32'(LIMIT))
    // the front end is busy hashing right after taking a beat
    `LPHI_ASSERT_NXT(a_front_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a full refusal only happens at the load limit
    `LPHI_ASSERT_IMP(a_full_at_limit, m_axis_tvalid && (status == ST_FULL),
        32'(live_entries) == (32'(LIMIT) & 32'h7ff))

endmodule

`default_nettype wire

### hdl/lphi_hash_front.sv
// front end: accepts items, classifies them and computes the home slot hash
`default_nettype none

module lphi_hash_front
    import lphi_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [CMD_W-1:0]   in_cmd,
    input  wire logic [KEY_W-1:0]   in_key,
    input  wire logic [VALUE_W-1:0] in_value,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output item_t                   push_item,
    output logic [IDX_W-1:0]        push_home
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t     state_reg, state_next;
    item_t       item_reg, item_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [1:0]  phase_reg, phase_next;
    logic        round_reg, round_next;

    logic [63:0] mconst;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul;
    logic [63:0] sum;
    kind_t       kind;

    // operand select for the shared 32x32 multiplier
    always_comb
    begin
        mconst = round_reg ? HASH_C2 : HASH_C1;
        case (phase_reg)
            2'd0:
            begin
                mul_a = h_reg[31:0];
                mul_b = mconst[31:0];
            end
            2'd1:
            begin
                mul_a = h_reg[31:0];
                mul_b = mconst[63:32];
            end
            default:
            begin
                mul_a = h_reg[63:32];
                mul_b = mconst[31:0];
            end
        endcase
    end

    assign mul = 64'(mul_a) * 64'(mul_b);
    assign sum = acc_reg + {prod_reg[31:0], 32'd0};

    // classify the incoming beat
    always_comb
    begin
        if (in_key == '0)
        begin
            kind = K_ZERO;
        end
        else
        begin
            case (in_cmd)
                CMD_INSERT: kind = K_INSERT;
                CMD_FIND:   kind = K_FIND;
                CMD_REMOVE: kind = K_REMOVE;
                default:    kind = K_NOP;
            endcase
        end
    end

    // sequencer: accept, two multiply rounds of four phases (skipped for a zero key or an unused command), hand over
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        h_next     = h_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        phase_next = phase_reg;
        round_next = round_reg;
        in_ready   = 1'b0;
        push_valid = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next.kind  = kind;
                    item_next.key   = in_key;
                    item_next.value = in_value;
                    h_next          = in_key ^ (in_key >> 30);
                    phase_next      = 2'd0;
                    round_next      = 1'b0;
                    if (kind == K_INSERT || kind == K_FIND || kind == K_REMOVE)
                    begin
                        state_next = F_HASH;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_HASH:
            begin
                prod_next  = mul;
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd1: acc_next = prod_reg;
                    2'd2: acc_next = sum;
                    2'd3:
                    begin
                        if (!round_reg)
                        begin
                            h_next     = sum ^ (sum >> 27);
                            round_next = 1'b1;
                        end
                        else
                        begin
                            h_next     = sum ^ (sum >> 31);
                            state_next = F_PUSH;
                        end
                    end
                    default: acc_next = acc_reg;
                endcase
            end
            F_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        h_reg     <= h_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        phase_reg <= phase_next;
        round_reg <= round_next;
    end

    assign push_item = item_reg;
    assign push_home = h_reg[IDX_W-1:0];

endmodule

`default_nettype wire

### hdl/lphi_queue.sv
// short fifo between the front and back ends
`default_nettype none

module lphi_queue
    import lphi_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_rd)
        begin
            rp_next = (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### hdl/lphi_probe_back.sv
// back end: probes the slot memories, updates the table and holds the result
`default_nettype none

module lphi_probe_back
    import lphi_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire item_t               q_item,
    input  wire logic [IDX_W-1:0]    q_home,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      out_status,
    output logic [VALUE_W-1:0]       out_found_value,
    output logic [LIVE_W-1:0]        out_live_entries
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int LIMIT = SLOTS - SLOTS / 4;

    typedef enum logic [5:0] {
        B_IDLE   = 6'b000001,
        B_START  = 6'b000010,
        B_READ   = 6'b000100,
        B_CHECK  = 6'b001000,
        B_RESULT = 6'b010000,
        B_CLEAR  = 6'b100000
    } bstate_t;

    bstate_t                  state_reg, state_next;
    item_t                    item_reg, item_next;
    logic [IDX_W-1:0]         s_reg, s_next;
    logic [IDX_W-1:0]         n_reg, n_next;
    logic [IDX_W-1:0]         clr_reg, clr_next;
    logic [CNT_W-1:0]         live_reg, live_next;
    logic                     wipe_reg, wipe_next;
    logic [STATUS_W-1:0]      st_reg, st_next;
    logic [VALUE_W-1:0]       fv_reg, fv_next;
    logic                     ov_reg, ov_next;
    logic [STATUS_W-1:0]      ost_reg, ost_next;
    logic [VALUE_W-1:0]       ofv_reg, ofv_next;
    logic [LIVE_W-1:0]        olive_reg, olive_next;

    // slot memories, read every cycle at the probe pointer
    logic [1:0]               tag_mem [SLOTS];
    logic [KEY_W-1:0]         key_mem [SLOTS];
    logic [HANDLE_BITS-1:0]   hnd_mem [SLOTS];
    logic [1:0]               tag_q;
    logic [KEY_W-1:0]         key_q;
    logic [HANDLE_BITS-1:0]   hnd_q;

    logic                     tag_we;
    logic [IDX_W-1:0]         tag_wa;
    logic [1:0]               tag_wd;
    logic                     data_we;
    logic                     hit;
    logic                     last_probe;

    assign hit        = (tag_q == TAG_LIVE) && (key_q == item_reg.key);
    assign last_probe = (n_reg == '1);

    // probe sequencer
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        s_next     = s_reg;
        n_next     = n_reg;
        clr_next   = clr_reg;
        live_next  = live_reg;
        wipe_next  = wipe_reg;
        st_next    = st_reg;
        fv_next    = fv_reg;
        ov_next    = ov_reg && !out_ready;
        ost_next   = ost_reg;
        ofv_next   = ofv_reg;
        olive_next = olive_reg;
        q_ready    = 1'b0;
        tag_we     = 1'b0;
        tag_wa     = s_reg;
        tag_wd     = TAG_LIVE;
        data_we    = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    item_next  = q_item;
                    s_next     = q_home;
                    n_next     = '0;
                    wipe_next  = 1'b0;
                    fv_next    = '0;
                    state_next = B_START;
                end
            end
            B_START:
            begin
                state_next = B_RESULT;
                case (item_reg.kind)
                    K_ZERO: st_next = ST_ZERO_KEY;
                    K_INSERT:
                    begin
                        if (live_reg >= CNT_W'(LIMIT))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = B_READ;
                        end
                    end
                    K_FIND:
                    begin
                        if (live_reg == '0)
                        begin
                            st_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            state_next = B_READ;
                        end
                    end
                    K_REMOVE: state_next = B_READ;
                    default: st_next = ST_NOT_FOUND;
                endcase
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                s_next     = s_reg + 1'b1;
                n_next     = n_reg + 1'b1;
                state_next = B_READ;
                if (item_reg.kind == K_INSERT)
                begin
                    if (tag_q != TAG_LIVE)
                    begin
                        tag_we     = 1'b1;
                        data_we    = 1'b1;
                        live_next  = live_reg + 1'b1;
                        st_next    = ST_OK;
                        state_next = B_RESULT;
                    end
                    else if (last_probe)
                    begin
                        st_next    = ST_FULL;
                        state_next = B_RESULT;
                    end
                end
                else
                begin
                    if (tag_q == TAG_EMPTY)
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = B_RESULT;
                    end
                    else if (hit)
                    begin
                        st_next    = ST_OK;
                        state_next = B_RESULT;
                        if (item_reg.kind == K_FIND)
                        begin
                            fv_next = VALUE_W'(hnd_q);
                        end
                        else
                        begin
                            tag_we    = 1'b1;
                            tag_wd    = TAG_TOMB;
                            live_next = live_reg - 1'b1;
                            wipe_next = (live_reg == CNT_W'(1));
                        end
                    end
                    else if (last_probe)
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = B_RESULT;
                    end
                end
            end
            B_RESULT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    ofv_next   = fv_reg;
                    olive_next = LIVE_W'(live_reg);
                    clr_next   = '0;
                    state_next = wipe_reg ? B_CLEAR : B_IDLE;
                end
            end
            B_CLEAR:
            begin
                tag_we   = 1'b1;
                tag_wa   = clr_reg;
                tag_wd   = TAG_EMPTY;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            live_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            live_reg  <= live_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        s_reg     <= s_next;
        n_reg     <= n_next;
        wipe_reg  <= wipe_next;
        st_reg    <= st_next;
        fv_reg    <= fv_next;
        ost_reg   <= ost_next;
        ofv_reg   <= ofv_next;
        olive_reg <= olive_next;
    end

    // slot memories
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
        if (data_we)
        begin
            key_mem[s_reg] <= item_reg.key;
            hnd_mem[s_reg] <= HANDLE_BITS'(item_reg.value);
        end
        tag_q <= tag_mem[s_reg];
        key_q <= key_mem[s_reg];
        hnd_q <= hnd_mem[s_reg];
    end

    assign out_valid        = ov_reg;
    assign out_status       = ost_reg;
    assign out_found_value  = ofv_reg;
    assign out_live_entries = olive_reg;

endmodule

`default_nettype wire

### test/tb_linear_probe_hash_index_unit.sv
// self-checking testbench of the linear probing hash index unit
`timescale 1ns / 1ps

module tb_linear_probe_hash_index_unit;
    import lphi_pkg::*;

    localparam int NSLOTS    = SLOTS_DEF;
    localparam int LOAD_MAX  = NSLOTS - NSLOTS / 4;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int TAIL_CYCLES = 4 * NSLOTS;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        bit                 drain_first;
    } op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  found;
        logic [LIVE_W-1:0]   live;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // shadow copy of the table
    logic [KEY_W-1:0]   tbl_key [NSLOTS];
    logic [VALUE_W-1:0] tbl_handle [NSLOTS];
    logic [1:0]         tbl_tag [NSLOTS];
    int                 tbl_live;

    op_t     pending_ops[$];
    answer_t answers_due[$];
    op_t     cur_op;
    int      errors = 0;
    int      results_seen = 0;
    int      send_gap = 0;
    bit      send_burst = 0;
    int      recv_stall = 0;
    int      recv_hold = 0;
    bit      recv_hold_done = 0;
    bit      recv_burst = 0;
    logic [KEY_W-1:0] key_pool [40];
    logic [KEY_W-1:0] fill_keys[$];

    linear_probe_hash_index_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic int home_of(logic [KEY_W-1:0] k);
        logic [63:0] h;
        h = k;
        h = h ^ (h >> 30);
        h = h * HASH_C1;
        h = h ^ (h >> 27);
        h = h * HASH_C2;
        h = h ^ (h >> 31);
        return int'(h & (NSLOTS - 1));
    endfunction

    // live slot holding k, or -1
    function automatic int find_slot(logic [KEY_W-1:0] k);
        int s;
        s = home_of(k);
        for (int n = 0; n < NSLOTS; n++) begin
            if (tbl_tag[s] == TAG_EMPTY)
                return -1;
            if (tbl_tag[s] == TAG_LIVE && tbl_key[s] == k)
                return s;
            s = (s + 1) & (NSLOTS - 1);
        end
        return -1;
    endfunction

    // apply one operation to the shadow table and queue its answer
    task automatic apply_op(op_t op);
        answer_t a;
        int s;
        a.status = ST_NOT_FOUND;
        a.found = '0;
        if (op.key == '0) begin
            a.status = ST_ZERO_KEY;
        end else if (op.cmd == CMD_INSERT) begin
            if (tbl_live + 1 > LOAD_MAX) begin
                a.status = ST_FULL;
            end else begin
                s = home_of(op.key);
                a.status = ST_FULL;
                for (int n = 0; n < NSLOTS; n++) begin
                    if (tbl_tag[s] != TAG_LIVE) begin
                        tbl_key[s] = op.key;
                        tbl_handle[s] = op.value;
                        tbl_tag[s] = TAG_LIVE;
                        tbl_live++;
                        a.status = ST_OK;
                        break;
                    end
                    s = (s + 1) & (NSLOTS - 1);
                end
            end
        end else if (op.cmd == CMD_FIND) begin
            if (tbl_live != 0) begin
                s = find_slot(op.key);
                if (s >= 0) begin
                    a.status = ST_OK;
                    a.found = tbl_handle[s];
                end
            end
        end else if (op.cmd == CMD_REMOVE) begin
            s = find_slot(op.key);
            if (s >= 0) begin
                tbl_tag[s] = TAG_TOMB;
                if (tbl_live > 0)
                    tbl_live--;
                if (tbl_live == 0)
                    foreach (tbl_tag[i]) tbl_tag[i] = TAG_EMPTY;
                a.status = ST_OK;
            end
        end
        a.live = tbl_live[LIVE_W-1:0];
        answers_due.push_back(a);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic add_op(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                          logic [VALUE_W-1:0] v, bit drain = 0);
        op_t op;
        op.cmd = c;
        op.key = k;
        op.value = v;
        op.drain_first = drain;
        pending_ops.push_back(op);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        if (k == '0) k = 64'd1;
        return k;
    endfunction

    // driver: offers one beat at a time from the pending queue
    always @(posedge clk) begin
        logic nv;
        nv = s_axis_tvalid;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_op(cur_op);
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].drain_first && answers_due.size() > 0)) begin
                    cur_op = pending_ops.pop_front();
                    s_axis_tdata <= {6'd0, cur_op.value, cur_op.key, cur_op.cmd};
                    nv = 1'b1;
                    if ($urandom_range(0, 63) == 0) send_burst = ~send_burst;
                    send_gap = send_burst ? 0 : pick_gap();
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // monitor: checks each result beat and throttles ready
    always @(posedge clk) begin
        answer_t a;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (answers_due.size() == 0) begin
                    $display("unexpected result beat %0h", m_axis_tdata);
                    errors++;
                end else begin
                    a = answers_due.pop_front();
                    if (m_axis_tdata[1:0] !== a.status)
                        report("status", 64'(m_axis_tdata[1:0]), 64'(a.status));
                    if (m_axis_tdata[33:2] !== a.found)
                        report("found_value", 64'(m_axis_tdata[33:2]), 64'(a.found));
                    if (m_axis_tdata[44:34] !== a.live)
                        report("live_entries", 64'(m_axis_tdata[44:34]), 64'(a.live));
                end
            end
            // one long hold-off so the block backs up into its input
            if (results_seen == 150 && !recv_hold_done) begin
                recv_hold_done = 1;
                recv_hold = 3000;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 63) == 0) recv_burst = ~recv_burst;
                if (!recv_burst && $urandom_range(0, 3) == 0) recv_stall = pick_gap();
            end
        end
    end

    // run limit
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and end of run
    initial begin
        logic [KEY_W-1:0] k;
        int r;
        foreach (tbl_tag[i]) tbl_tag[i] = TAG_EMPTY;
        tbl_live = 0;

        // directed part
        add_op(CMD_FIND, 64'h1, 32'h0);
        add_op(CMD_REMOVE, 64'h1, 32'h0);
        add_op(CMD_INSERT, '1, '1);
        add_op(CMD_INSERT, 64'h1, 32'h0);
        add_op(CMD_FIND, '1, 32'h0);
        add_op(CMD_FIND, 64'h1, '1);
        add_op(CMD_FIND, 64'h8000_0000_0000_0000, 32'h0);
        add_op(CMD_INSERT, 64'h1, 32'h5a5a_a5a5);
        add_op(CMD_FIND, 64'h1, 32'h0);
        add_op(CMD_REMOVE, 64'h1, 32'h0);
        add_op(CMD_FIND, 64'h1, 32'h0);
        add_op(CMD_UNUSED, '1, '1);
        add_op(CMD_INSERT, 64'h0, '1);
        add_op(CMD_FIND, 64'h0, 32'h0);
        add_op(CMD_REMOVE, 64'h0, 32'h0);
        add_op(CMD_UNUSED, 64'h0, 32'h0);
        add_op(CMD_REMOVE, 64'h1, 32'h0);
        add_op(CMD_REMOVE, 64'h1234, 32'h0);
        add_op(CMD_REMOVE, '1, 32'h0);
        add_op(CMD_FIND, '1, 32'h0);
        add_op(CMD_INSERT, 64'h77, 32'h1, 1);

        // fill to the load limit and past it, then empty the table
        for (int i = 0; i < LOAD_MAX + 3; i++) begin
            k = rand_key();
            fill_keys.push_back(k);
            add_op(CMD_INSERT, k, $urandom);
            if (i % 50 == 0)
                add_op(CMD_FIND, fill_keys[$urandom_range(0, fill_keys.size() - 1)], 32'h0);
        end
        add_op(CMD_FIND, rand_key(), 32'h0);
        add_op(CMD_REMOVE, 64'h77, 32'h0);
        foreach (fill_keys[i]) begin
            add_op(CMD_REMOVE, fill_keys[i], 32'h0);
            if (i % 97 == 0)
                add_op(CMD_INSERT, fill_keys[i], $urandom);
        end
        foreach (fill_keys[i])
            if (i % 97 == 0) add_op(CMD_REMOVE, fill_keys[i], 32'h0);

        // random churn over a small key pool
        foreach (key_pool[i]) key_pool[i] = rand_key();
        for (int i = 0; i < 300; i++) begin
            r = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, 39)];
            if (i == 150)
                add_op(CMD_FIND, k, $urandom, 1);
            else if (r < 40)
                add_op(CMD_INSERT, k, $urandom);
            else if (r < 70)
                add_op(CMD_FIND, k, $urandom);
            else if (r < 94)
                add_op(CMD_REMOVE, k, $urandom);
            else if (r < 97)
                add_op(CMD_UNUSED, rand_key(), $urandom);
            else
                add_op(2'($urandom_range(0, 3)), 64'h0, $urandom);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !s_axis_tvalid && answers_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/lphi_pkg.sv
hdl/lphi_hash_front.sv
hdl/lphi_queue.sv
hdl/lphi_probe_back.sv
hdl/linear_probe_hash_index_unit.sv
test/tb_linear_probe_hash_index_unit.sv
